@@ rtl/core/bfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W       = 20;
  localparam int SIZE_W       = 12;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int MAX_REQ      = PAGE_BYTES - HEADER_BYTES;

  localparam int DEF_FREE_SLOTS = 64;
  localparam int DEF_HEAP_BYTES = 1048576;

  localparam logic       KIND_ALLOC   = 1'b0;
  localparam logic       KIND_FREE    = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_PAGE   = 2'd1;
  localparam logic [1:0] ST_LOST      = 2'd2;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_PICK,
    S_RECYCLE,
    S_SPLIT,
    S_FREE_RD,
    S_PUSH_RD,
    S_PUSH_WR,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/bfa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/best_fit_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a paged heap with a LIFO table of free blocks.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one word (allocate or free). The
// result shows on obj_addr and status for one cycle with done high; it is not
// held, so the receiver must take it then. An allocation walks the free table
// one entry per cycle through the table RAM, at most FREE_SLOTS entries; a free
// reads the stored size and pushes the block onto the table without a walk.
// The next word can be taken in the cycle after done.
// After reset the block stays busy while it links the spare chain in the table RAM.
module best_fit_block_allocator
  import bfa_pkg::*;
#(
  parameter int FREE_SLOTS = DEF_FREE_SLOTS,
  parameter int HEAP_BYTES = DEF_HEAP_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [SIZE_W-1:0] req_size,
  input  logic [ADDR_W-1:0] req_addr,
  output logic              done,
  output logic [ADDR_W-1:0] obj_addr,
  output logic [1:0]        status
);

  localparam int SW    = $clog2(FREE_SLOTS);
  localparam int LW    = $clog2(FREE_SLOTS + 1);
  localparam int HW    = $clog2(HEAP_BYTES);
  localparam int PW    = HW + 1;
  localparam int DEPTH = HEAP_BYTES / 8;
  localparam int DW    = HW + SIZE_W;
  localparam logic [LW-1:0] NULL_IDX = LW'(FREE_SLOTS);

  state_t state, state_next;

  logic [LW-1:0]     clr, cur, prev, best, best_prev, best_link, steps;
  logic [LW-1:0]     list_head, spare_head;
  logic              have;
  logic [SIZE_W-1:0] best_bytes, blk_bytes, push_bytes;
  logic [HW-1:0]     best_base, blk_base, push_base;
  logic [SIZE_W:0]   size_r;
  logic [PW-1:0]     next_page;

  logic              link_we, data_we, store_we;
  logic [SW-1:0]     link_addr, data_addr;
  logic [LW-1:0]     link_wdata, link_rdata;
  logic [DW-1:0]     data_wdata, data_rdata;
  logic [HW-4:0]     store_addr;
  logic [SIZE_W-1:0] store_wdata, store_rdata;

  logic [SIZE_W-1:0] d_bytes;
  logic [HW-1:0]     d_base;
  logic              hit, walk_on;
  logic [SIZE_W:0]   round_sz, rest;
  logic              split;
  logic [31:0]       hdr32, obj_sum;
  logic              free_ok, page_ok;

  assign d_base  = data_rdata[DW-1:SIZE_W];
  assign d_bytes = data_rdata[SIZE_W-1:0];
  assign hit     = ({1'b0, d_bytes} >= size_r) && (!have || d_bytes < best_bytes);
  assign walk_on = (link_rdata != NULL_IDX) && (LW'(steps + 1'b1) != NULL_IDX);

  always_comb begin
    round_sz = ({1'b0, req_size} + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7);
    if (round_sz == '0) begin
      round_sz = (SIZE_W+1)'(8);
    end
  end

  assign hdr32   = ({{(32-ADDR_W){1'b0}}, req_addr} - 32'(HEADER_BYTES)) & ~32'd7;
  assign free_ok = (req_addr >= ADDR_W'(HEADER_BYTES)) && (hdr32 < 32'(HEAP_BYTES));
  assign page_ok = (32'(next_page) + 32'(PAGE_BYTES)) <= 32'(HEAP_BYTES);
  assign rest    = {1'b0, blk_bytes} - size_r;
  assign split   = rest > (SIZE_W+1)'(HEADER_BYTES);
  assign obj_sum = 32'(blk_base) + 32'(HEADER_BYTES);

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  bfa_ram #(.WIDTH(LW), .DEPTH(FREE_SLOTS)) u_link (
    .clk(clk), .we(link_we), .addr(link_addr), .wdata(link_wdata), .rdata(link_rdata)
  );

  bfa_ram #(.WIDTH(DW), .DEPTH(FREE_SLOTS)) u_data (
    .clk(clk), .we(data_we), .addr(data_addr), .wdata(data_wdata), .rdata(data_rdata)
  );

  bfa_ram #(.WIDTH(SIZE_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(store_we), .addr(store_addr), .wdata(store_wdata), .rdata(store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    link_we     = 1'b0;
    link_addr   = cur[SW-1:0];
    link_wdata  = list_head;
    data_we     = 1'b0;
    data_addr   = cur[SW-1:0];
    data_wdata  = {push_base, push_bytes};
    store_we    = 1'b0;
    store_addr  = hdr32[HW-1:3];
    store_wdata = size_r[SIZE_W-1:0];
    case (state)
      S_INIT: begin
        link_we    = 1'b1;
        link_addr  = clr[SW-1:0];
        link_wdata = LW'(clr + 1'b1);
        if (LW'(clr + 1'b1) == NULL_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        link_addr = list_head[SW-1:0];
        data_addr = list_head[SW-1:0];
        if (start) begin
          if (kind == KIND_FREE) begin
            state_next = free_ok ? S_FREE_RD : S_DONE;
          end else if (round_sz > (SIZE_W+1)'(MAX_REQ)) begin
            state_next = S_DONE;
          end else if (list_head == NULL_IDX) begin
            state_next = S_PICK;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        // follow the link straight from the RAM output
        link_addr = link_rdata[SW-1:0];
        data_addr = link_rdata[SW-1:0];
        if (!walk_on) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (have) begin
          link_we    = (best_prev != NULL_IDX);
          link_addr  = best_prev[SW-1:0];
          link_wdata = best_link;
          state_next = S_RECYCLE;
        end else if (page_ok) begin
          state_next = S_SPLIT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RECYCLE: begin
        link_we    = 1'b1;
        link_addr  = best[SW-1:0];
        link_wdata = spare_head;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        store_we    = 1'b1;
        store_addr  = blk_base[HW-1:3];
        store_wdata = split ? size_r[SIZE_W-1:0] : blk_bytes;
        if (split && spare_head != NULL_IDX) begin
          state_next = S_PUSH_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE_RD: begin
        state_next = (spare_head != NULL_IDX) ? S_PUSH_RD : S_DONE;
      end
      S_PUSH_RD: begin
        link_addr  = spare_head[SW-1:0];
        state_next = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        link_we    = 1'b1;
        link_addr  = spare_head[SW-1:0];
        link_wdata = list_head;
        data_we    = 1'b1;
        data_addr  = spare_head[SW-1:0];
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      list_head  <= NULL_IDX;
      spare_head <= '0;
      next_page  <= '0;
    end else begin
      case (state)
        S_INIT: begin
          clr <= LW'(clr + 1'b1);
        end
        S_IDLE: begin
          obj_addr  <= '0;
          status    <= (start && kind == KIND_ALLOC && round_sz > (SIZE_W+1)'(MAX_REQ)) ?
                       ST_NO_PAGE : ST_OK;
          size_r    <= round_sz;
          cur       <= list_head;
          prev      <= NULL_IDX;
          steps     <= '0;
          have      <= 1'b0;
          push_base <= hdr32[HW-1:0];
        end
        S_WALK: begin
          if (hit) begin
            have       <= 1'b1;
            best       <= cur;
            best_prev  <= prev;
            best_base  <= d_base;
            best_bytes <= d_bytes;
            best_link  <= link_rdata;
          end
          prev  <= cur;
          cur   <= link_rdata;
          steps <= LW'(steps + 1'b1);
        end
        S_PICK: begin
          if (have) begin
            blk_base  <= best_base;
            blk_bytes <= best_bytes;
            if (best_prev == NULL_IDX) begin
              list_head <= best_link;
            end
          end else if (page_ok) begin
            blk_base  <= next_page[HW-1:0];
            blk_bytes <= SIZE_W'(MAX_REQ);
            next_page <= PW'(next_page + PW'(PAGE_BYTES));
          end else begin
            status <= ST_NO_PAGE;
          end
        end
        S_RECYCLE: begin
          spare_head <= best;
        end
        S_SPLIT: begin
          obj_addr   <= obj_sum[ADDR_W-1:0];
          push_base  <= HW'(obj_sum[HW-1:0] + HW'(size_r));
          push_bytes <= SIZE_W'(rest - (SIZE_W+1)'(HEADER_BYTES));
          if (split && spare_head == NULL_IDX) begin
            status <= ST_LOST;
          end
        end
        S_FREE_RD: begin
          push_bytes <= store_rdata;
          if (spare_head == NULL_IDX) begin
            status <= ST_LOST;
          end
        end
        S_PUSH_WR: begin
          spare_head <= link_rdata;
          list_head  <= spare_head;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/bfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_assertions
  import bfa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [ADDR_W-1:0] obj_addr,
  input logic [1:0]        status
);

  // an accepted word keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("not busy after accept");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result shown longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result while idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_NO_PAGE |-> obj_addr == '0) else $error("address on failed word");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status != 2'd3) else $error("bad status code");

endmodule

bind best_fit_block_allocator bfa_assertions u_bfa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .obj_addr(obj_addr), .status(status)
);
